// ===== rtl/dcm_pkg.sv =====
// shared types, constants and helpers for the drive command mux
package dcm_pkg;

  localparam int unsigned SilenceLimitDef = 40;
  localparam int unsigned CountCapDef     = 10000;
  localparam int unsigned SIL_W           = 14;
  localparam int unsigned DIV_NUM_W       = 28;
  localparam int unsigned DIV_DEN_W       = 13;
  localparam int unsigned DIV_CNT_W       = 5;

  localparam logic signed [15:0] JOY_EDGE  = 16'sd3276;
  localparam logic signed [15:0] JOY_FORCE = 16'sd3277;
  localparam logic signed [15:0] THR_CAP   = 16'sd7045;

  typedef enum logic [2:0] {
    OP_PLANNER  = 3'd0,
    OP_WAYPOINT = 3'd1,
    OP_JOY      = 3'd2,
    OP_STEER_FB = 3'd3,
    OP_THR_FB   = 3'd4,
    OP_RUNSTOP  = 3'd5,
    OP_AUTOMAN  = 3'd6,
    OP_UNUSED   = 3'd7
  } dcm_op_t;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_PLANNER  = 2'd1,
    SRC_WAYPOINT = 2'd2,
    SRC_JOY      = 2'd3
  } dcm_src_t;

  typedef enum logic [1:0] {
    CMDR_PLANNER  = 2'd0,
    CMDR_WAYPOINT = 2'd1,
    CMDR_JOY      = 2'd2
  } dcm_cmdr_t;

  typedef enum logic [2:0] {
    CFG_STEER_SCALE  = 3'd0,
    CFG_THR_SCALE    = 3'd1,
    CFG_STEER_CENTER = 3'd2,
    CFG_THR_CENTER   = 3'd3,
    CFG_THR_PWM_MAX  = 3'd4,
    CFG_THR_PWM_MIN  = 3'd5,
    CFG_MAX_THROTTLE = 3'd6,
    CFG_STEER_TRIM   = 3'd7
  } dcm_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_PWM, S_DIVS, S_DIVS_W, S_DIVT, S_DIVT_W, S_OUT
  } dcm_state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] cmd_steering;
    logic signed [15:0] cmd_throttle;
    logic               sender_matches;
    logic [11:0]        feedback_pwm;
    logic               flag_value;
  } dcm_in_t;

  typedef struct packed {
    logic [11:0]        steer_pwm;
    logic [11:0]        throttle_pwm;
    logic [1:0]         commander;
    logic               autonomous_enabled;
    logic               motion_enabled;
    logic signed [15:0] steer_feedback;
    logic signed [15:0] throttle_feedback;
  } dcm_out_t;

  typedef struct packed {
    logic load_in;
    logic upd;
    logic select;
    logic mul;
    logic pwm;
    logic div_start;
    logic div_sel;
    logic load_out;
  } dcm_cmd_t;

  typedef struct packed {
    logic is_joy;
    logic div_done;
    logic out_full;
  } dcm_stat_t;

  function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == 16'sh8000) r = 16'sh7fff;
    else r = -v;
    return r;
  endfunction

  // divide by 2^14, round to nearest, ties away from zero
  function automatic logic signed [15:0] rnd14(input logic signed [28:0] p);
    logic [28:0] mag;
    logic [28:0] q;
    mag = p[28] ? 29'(-p) : 29'(p);
    q   = (mag + 29'd8192) >> 14;
    return p[28] ? 16'(-q) : 16'(q);
  endfunction

  function automatic logic [11:0] sat12(input logic signed [17:0] v);
    logic [11:0] r;
    if (v < 18'sd0) r = 12'd0;
    else if (v > 18'sd4095) r = 12'd4095;
    else r = v[11:0];
    return r;
  endfunction

endpackage

// ===== rtl/dcm_div.sv =====
// restoring divider, one quotient bit per cycle
module dcm_div import dcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/dcm_dp.sv =====
// datapath: source selection state, pwm mapping and feedback scaling
module dcm_dp import dcm_pkg::*; #(
  parameter int unsigned SILENCE_LIMIT = SilenceLimitDef,
  parameter int unsigned COUNT_CAP     = CountCapDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dcm_cmd_t  cmd,
  output dcm_stat_t stat,
  input  dcm_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dcm_out_t  out_data,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [11:0] steer_scale_r, thr_scale_r;
  logic [11:0]        steer_center_r, thr_center_r, thr_max_r, thr_min_r;
  logic [14:0]        max_thr_r;
  logic signed [15:0] steer_trim_r;

  dcm_in_t            in_r;
  dcm_src_t           src_r, src_nxt;
  logic signed [15:0] pl_s_r, pl_t_r, wp_s_r, wp_t_r, held_s_r, held_t_r;
  logic [SIL_W-1:0]   sil_r, sil_nxt;
  logic [11:0]        sfb_r, tfb_r;
  logic               automan_r, runstop_r;
  dcm_cmdr_t          cmdr_r, cmdr_nxt;

  logic signed [15:0] hs, ht, np_t;
  logic signed [16:0] mt17, neg_mt17, np17;

  logic signed [16:0] ssum;
  logic signed [28:0] prod_s_c, prod_t_c, prod_s_r, prod_t_r;
  logic signed [17:0] spwm, tpwm;
  logic [11:0]        steer_pwm_r, thr_pwm_r;

  logic [11:0]        fb_pwm, fb_center;
  logic signed [11:0] fb_scale;
  logic signed [12:0] diff;
  logic [11:0]        an, ad;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic               div_done;
  logic signed [15:0] fb_norm;
  logic signed [15:0] sfbn_r, tfbn_r;

  dcm_out_t out_r;
  logic     out_valid_r, out_valid_nxt;

  // source selection for a joystick word
  always_comb begin
    hs       = held_s_r;
    ht       = held_t_r;
    src_nxt  = src_r;
    np_t     = neg16(pl_t_r);
    np17     = {np_t[15], np_t};
    mt17     = signed'({2'b00, max_thr_r});
    neg_mt17 = -mt17;
    if (src_r == SRC_PLANNER) begin
      hs = neg16(pl_s_r);
      if (np17 > mt17) ht = mt17[15:0];
      else if (np17 < neg_mt17) ht = neg_mt17[15:0];
      else ht = np_t;
    end else if (src_r == SRC_WAYPOINT) begin
      hs = wp_s_r;
      ht = wp_t_r;
    end
    if (src_r == SRC_PLANNER || src_r == SRC_WAYPOINT) begin
      if (in_r.cmd_throttle > JOY_EDGE) ht = JOY_FORCE;
      if (in_r.cmd_throttle < -JOY_EDGE) ht = -JOY_FORCE;
    end
    if (sil_r > SIL_W'(SILENCE_LIMIT)) begin
      hs      = in_r.cmd_steering;
      ht      = neg16(in_r.cmd_throttle);
      src_nxt = SRC_JOY;
    end
    if (ht > THR_CAP) ht = THR_CAP;
    case (src_nxt)
      SRC_WAYPOINT: cmdr_nxt = CMDR_WAYPOINT;
      SRC_PLANNER: begin
        cmdr_nxt = CMDR_PLANNER;
        src_nxt  = SRC_NONE;
      end
      default: cmdr_nxt = CMDR_JOY;
    endcase
    sil_nxt = (sil_r < SIL_W'(COUNT_CAP)) ? sil_r + 1'b1 : sil_r;
  end

  assign ssum     = {held_s_r[15], held_s_r} + {steer_trim_r[15], steer_trim_r};
  assign prod_s_c = $signed({{17{steer_scale_r[11]}}, steer_scale_r})
                  * $signed({{12{ssum[16]}}, ssum});
  assign prod_t_c = $signed({{17{thr_scale_r[11]}}, thr_scale_r})
                  * $signed({{13{held_t_r[15]}}, held_t_r});

  always_comb begin
    logic signed [15:0] rs, rt;
    rs   = rnd14(prod_s_r);
    rt   = rnd14(prod_t_r);
    spwm = signed'({6'b0, steer_center_r}) + {{2{rs[15]}}, rs};
    tpwm = signed'({6'b0, thr_center_r}) + {{2{rt[15]}}, rt};
    if (tpwm > signed'({6'b0, thr_max_r})) tpwm = signed'({6'b0, thr_max_r});
    else if (tpwm < signed'({6'b0, thr_min_r})) tpwm = signed'({6'b0, thr_min_r});
  end

  // feedback division setup and saturation
  always_comb begin
    fb_pwm    = cmd.div_sel ? tfb_r : sfb_r;
    fb_center = cmd.div_sel ? thr_center_r : steer_center_r;
    fb_scale  = cmd.div_sel ? thr_scale_r : steer_scale_r;
    diff      = signed'({1'b0, fb_pwm}) - signed'({1'b0, fb_center});
    an        = diff[12] ? 12'(-diff) : diff[11:0];
    ad        = fb_scale[11] ? 12'(-fb_scale) : 12'(fb_scale);
    div_num   = {1'b0, an, 15'b0} + DIV_NUM_W'(ad);
    div_den   = {ad, 1'b0};
    if (fb_scale == 12'sd0) begin
      if (diff > 13'sd0) fb_norm = 16'sh7fff;
      else if (diff < 13'sd0) fb_norm = 16'sh8000;
      else fb_norm = 16'sd0;
    end else if (diff[12] ^ fb_scale[11]) begin
      if (div_quo > DIV_NUM_W'(32768)) fb_norm = 16'sh8000;
      else fb_norm = 16'(-div_quo);
    end else begin
      if (div_quo > DIV_NUM_W'(32767)) fb_norm = 16'sh7fff;
      else fb_norm = div_quo[15:0];
    end
  end

  dcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_scale_r  <= 12'sd500;
      thr_scale_r    <= 12'sd500;
      steer_center_r <= 12'd1500;
      thr_center_r   <= 12'd1500;
      thr_max_r      <= 12'd1600;
      thr_min_r      <= 12'd1250;
      max_thr_r      <= 15'd16384;
      steer_trim_r   <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEER_SCALE:  steer_scale_r  <= cfg_data[11:0];
        CFG_THR_SCALE:    thr_scale_r    <= cfg_data[11:0];
        CFG_STEER_CENTER: steer_center_r <= cfg_data[11:0];
        CFG_THR_CENTER:   thr_center_r   <= cfg_data[11:0];
        CFG_THR_PWM_MAX:  thr_max_r      <= cfg_data[11:0];
        CFG_THR_PWM_MIN:  thr_min_r      <= cfg_data[11:0];
        CFG_MAX_THROTTLE: max_thr_r      <= cfg_data[14:0];
        CFG_STEER_TRIM:   steer_trim_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= SRC_NONE;
      pl_s_r      <= '0;
      pl_t_r      <= '0;
      wp_s_r      <= '0;
      wp_t_r      <= '0;
      held_s_r    <= '0;
      held_t_r    <= '0;
      sil_r       <= '0;
      sfb_r       <= '0;
      tfb_r       <= '0;
      automan_r   <= 1'b0;
      runstop_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.upd) begin
        case (in_r.operation)
          OP_PLANNER: begin
            pl_s_r <= in_r.cmd_steering;
            pl_t_r <= in_r.cmd_throttle;
            src_r  <= SRC_PLANNER;
            sil_r  <= '0;
          end
          OP_WAYPOINT: begin
            if (in_r.sender_matches) begin
              wp_s_r <= in_r.cmd_steering;
              wp_t_r <= in_r.cmd_throttle;
              src_r  <= SRC_WAYPOINT;
            end
            sil_r <= '0;
          end
          OP_STEER_FB: sfb_r     <= in_r.feedback_pwm;
          OP_THR_FB:   tfb_r     <= in_r.feedback_pwm;
          OP_RUNSTOP:  runstop_r <= in_r.flag_value;
          OP_AUTOMAN:  automan_r <= in_r.flag_value;
          default: ;
        endcase
      end else if (cmd.select) begin
        held_s_r <= hs;
        held_t_r <= ht;
        src_r    <= src_nxt;
        sil_r    <= sil_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.select) cmdr_r <= cmdr_nxt;
    if (cmd.mul) begin
      prod_s_r <= prod_s_c;
      prod_t_r <= prod_t_c;
    end
    if (cmd.pwm) begin
      steer_pwm_r <= sat12(spwm);
      thr_pwm_r   <= sat12(tpwm);
    end
    if (div_done) begin
      if (cmd.div_sel) tfbn_r <= fb_norm;
      else sfbn_r <= fb_norm;
    end
    if (cmd.load_out) begin
      out_r.steer_pwm          <= steer_pwm_r;
      out_r.throttle_pwm       <= thr_pwm_r;
      out_r.commander          <= cmdr_r;
      out_r.autonomous_enabled <= automan_r;
      out_r.motion_enabled     <= runstop_r;
      out_r.steer_feedback     <= sfbn_r;
      out_r.throttle_feedback  <= tfbn_r;
    end
  end

  assign stat.is_joy   = (in_r.operation == OP_JOY);
  assign stat.div_done = div_done;
  assign stat.out_full = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// ===== rtl/dcm_ctrl.sv =====
// controller state machine sequencing one word at a time
module dcm_ctrl import dcm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dcm_stat_t stat,
  output dcm_cmd_t  cmd
);

  dcm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = stat.is_joy ? S_MUL : S_IDLE;
      S_MUL:    state_nxt = S_PWM;
      S_PWM:    state_nxt = S_DIVS;
      S_DIVS:   state_nxt = S_DIVS_W;
      S_DIVS_W: if (stat.div_done) state_nxt = S_DIVT;
      S_DIVT:   state_nxt = S_DIVT_W;
      S_DIVT_W: if (stat.div_done) state_nxt = S_OUT;
      S_OUT:    if (!stat.out_full) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        cmd.select = stat.is_joy;
        cmd.upd    = !stat.is_joy;
      end
      S_MUL:    cmd.mul = 1'b1;
      S_PWM:    cmd.pwm = 1'b1;
      S_DIVS:   cmd.div_start = 1'b1;
      S_DIVS_W: ;
      S_DIVT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_DIVT_W: cmd.div_sel = 1'b1;
      S_OUT:    cmd.load_out = !stat.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_DIVS_W || state_r == S_DIVT_W))
    else $error("divider finished outside a wait state");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_full)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/drive_command_mux_pwm.sv =====
// drive command mux: source arbitration and servo pwm mapping, top level
//
// in channel (in_valid/in_ready/in_data) takes one word per operation:
// planner, waypoint and joystick commands, feedback pwm and flags.
// only a joystick word gives a result on the out channel.
// cfg channel writes one of eight registers by index; cfg_ready is always
// high, and writes belong while the block is idle.
// a non-joystick word is decoded and the block then returns to idle for
// the next word. a joystick word runs selection, multiply, pwm rounding,
// then two feedback divisions (28 quotient bits each) through one shared
// bit-serial divider; its result is loaded once the output is free, and no
// new word is taken before that.
// the result sits in an output register; the next word is accepted while
// it waits, and a later joystick result waits in its final state until the
// receiver takes the earlier one.
// reset (synchronous, rst_n low) loads register defaults, clears the stored
// commands, feedback and flags, the source, the silence count and the output valid.
module drive_command_mux_pwm import dcm_pkg::*; #(
  parameter int unsigned SILENCE_LIMIT = SilenceLimitDef,
  parameter int unsigned COUNT_CAP     = CountCapDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  dcm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output dcm_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dcm_cmd_t  cmd;
  dcm_stat_t stat;

  assign cfg_ready = 1'b1;

  dcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dcm_dp #(
    .SILENCE_LIMIT (SILENCE_LIMIT),
    .COUNT_CAP     (COUNT_CAP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
